/* rtl/core/krb_pkg.sv */
// ----------------------------------------------------------------------------
// krb_pkg
// shared types, codes and defaults for the key ring buffer
// ----------------------------------------------------------------------------
package krb_pkg;

   localparam int DEPTH_DEF  = 128;
   localparam int CODE_W_DEF = 16;

   // widest values the cell control bus has to carry
   localparam int CODE_W_MAX = 16;
   localparam int LEN_W_MAX  = 12;

   localparam int FUNC_W  = 3;
   localparam int FILL_W  = 7;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 64;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PURGE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd5;

   localparam logic [CSR_A_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_ARROW  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_MOUSE  = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_BUTTON = 2'd3;

   localparam logic [1:0] MODE_ANSI = 2'd1;
   localparam logic [1:0] MODE_VT52 = 2'd2;

   localparam logic [7:0] BYTE_ESC     = 8'd27;
   localparam logic [7:0] BYTE_CR      = 8'd13;
   localparam logic [7:0] BYTE_BRACKET = 8'h5B;

   // escape letters for left, up, right, down
   function automatic logic [7:0] dir_letter(input logic [1:0] d);
      case (d)
         2'd0:    dir_letter = 8'h44;
         2'd1:    dir_letter = 8'h41;
         2'd2:    dir_letter = 8'h43;
         default: dir_letter = 8'h42;
      endcase
   endfunction

   // cell operations
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_SHL   = 2'd1;
   localparam logic [1:0] CELL_SHR   = 2'd2;
   localparam logic [1:0] CELL_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0]            op;
      logic [LEN_W_MAX-1:0]  len;
      logic [CODE_W_MAX-1:0] data;
   } cell_ctrl_type;

endpackage

/* rtl/core/krb_cell.sv */
// ----------------------------------------------------------------------------
// krb_cell
// one slot of the key chain: hold, shift toward head, shift away, or load
// ----------------------------------------------------------------------------
module krb_cell #(
   parameter int CODE_WIDTH = 16,
   parameter int LEN_W      = 7,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  krb_pkg::cell_ctrl_type ctrl,
   input  logic [CODE_WIDTH-1:0] from_prev,
   input  logic [CODE_WIDTH-1:0] from_next,
   output logic [CODE_WIDTH-1:0] value
);
   import krb_pkg::*;

   logic [CODE_WIDTH-1:0] value_ff, value_in;
   logic [LEN_W-1:0]      len;
   logic [LEN_W-1:0]      my_idx;
   logic [LEN_W-1:0]      my_idx_p1;

   assign len       = ctrl.len[LEN_W-1:0];
   assign my_idx    = LEN_W'(IDX);
   assign my_idx_p1 = LEN_W'(IDX + 1);

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_SHL: begin
            // queue rotate: last live cell takes the old head
            if (my_idx_p1 < len) value_in = from_next;
            else if (my_idx_p1 == len) value_in = ctrl.data[CODE_WIDTH-1:0];
         end
         CELL_SHR:   value_in = from_prev;
         CELL_WRITE: if (my_idx == len) value_in = ctrl.data[CODE_WIDTH-1:0];
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

/* rtl/core/key_ring_buffer_with_escape_translate_unit.sv */
// ----------------------------------------------------------------------------
// key_ring_buffer_with_escape_translate_unit
// key-code queue with escape translation, built as a row of shifting cells
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH-1 key codes in a row of cells whose first cell
// is always the head. One transaction is handled at a time and answered with
// exactly one result. Put, push, pop, peek, clear and code zero do their work
// as the request is accepted; a translated ANSI sequence stores three bytes and a
// VT52 sequence two (one cell write per stored byte). Purge leaves its accept cycle
// and then walks the live entries through the head cell, one per cycle. The
// result is held in the result register:
// the result waits there until taken, and the next request is taken in the
// cycle after that.
module key_ring_buffer_with_escape_translate_unit #(
   parameter int DEPTH      = krb_pkg::DEPTH_DEF,
   parameter int CODE_WIDTH = krb_pkg::CODE_W_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [krb_pkg::FUNC_W-1:0]   req_func,
   input  logic [15:0]                  req_key_code,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_accepted,
   output logic [15:0]                  rsp_key_out,
   output logic                         rsp_found,
   output logic [krb_pkg::FILL_W-1:0]   rsp_fill_level,
   output logic                         rsp_is_full,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [krb_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [krb_pkg::CSR_D_W-1:0]  csr_wr_data
);
   import krb_pkg::*;

   localparam int NCELL = DEPTH - 1;
   localparam int CNT_W = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SEQ   = 2'd1;
   localparam logic [1:0] ST_PURGE = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH - 1);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [63:0] arrow_ff, mouse_ff;
   logic [31:0] button_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         arrow_ff  <= '0;
         mouse_ff  <= '0;
         button_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wr_data[1:0];
            CSR_ARROW:  arrow_ff  <= csr_wr_data;
            CSR_MOUSE:  mouse_ff  <= csr_wr_data;
            CSR_BUTTON: button_ff <= csr_wr_data[31:0];
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   // control state
   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      left_ff, left_in;       // entries still to visit in purge
   logic [1:0]            seq_n_ff, seq_n_in;     // escape bytes still to store
   logic [7:0]            letter_ff, letter_in;
   logic [CODE_WIDTH-1:0] match_ff, match_in;     // purge target code
   logic                  acc_ff, acc_in;
   logic [15:0]           key_ff, key_in;
   logic                  found_ff, found_in;

   cell_ctrl_type         ctrl;
   logic [CODE_WIDTH-1:0] cell_q [NCELL];
   logic [CODE_WIDTH-1:0] head;

   assign head = cell_q[0];

   // request decode helpers
   logic [CODE_WIDTH-1:0] code;
   logic                  full;
   logic                  xlate;
   logic [3:0]            dir_hit;
   logic [1:0]            dir_sel;
   logic                  btn_l, btn_r;
   logic [CNT_W:0]        room_need;

   assign code  = req_key_code[CODE_WIDTH-1:0];
   assign full  = (count_ff >= FULL_CNT);
   assign xlate = (mode_ff == MODE_ANSI) || (mode_ff == MODE_VT52);
   assign btn_l = (code == button_ff[CODE_WIDTH-1:0]);
   assign btn_r = (code == button_ff[16 +: CODE_WIDTH]);

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         dir_hit[d] = (code == arrow_ff[16*d +: CODE_WIDTH]) ||
                      (code == mouse_ff[16*d +: CODE_WIDTH]);
      end
      // first match wins: left, up, right, down
      if (dir_hit[0])      dir_sel = 2'd0;
      else if (dir_hit[1]) dir_sel = 2'd1;
      else if (dir_hit[2]) dir_sel = 2'd2;
      else                 dir_sel = 2'd3;
   end

   assign room_need = {1'b0, count_ff} + ((mode_ff == MODE_ANSI) ? (CNT_W+1)'(3)
                                                                  : (CNT_W+1)'(2));

   function automatic cell_ctrl_type mk_ctrl(input logic [1:0] op,
                                             input logic [CNT_W-1:0] len,
                                             input logic [CODE_WIDTH-1:0] data);
      cell_ctrl_type c;
      c.op   = op;
      c.len  = LEN_W_MAX'(len);
      c.data = CODE_W_MAX'(data);
      return c;
   endfunction

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      seq_n_in  = seq_n_ff;
      letter_in = letter_ff;
      match_in  = match_ff;
      acc_in    = acc_ff;
      key_in    = key_ff;
      found_in  = found_ff;
      ctrl      = mk_ctrl(CELL_HOLD, count_ff, head);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in   = 1'b0;
               key_in   = '0;
               found_in = 1'b0;
               state_in = ST_RESP;
               case (req_func)
                  FUNC_PUT: begin
                     if (code == '0) begin
                        acc_in = 1'b1;
                     end else if (!full) begin
                        if (xlate && (|dir_hit)) begin
                           if (room_need <= {1'b0, FULL_CNT}) begin
                              // escape byte now, the rest over the next cycles
                              acc_in    = 1'b1;
                              ctrl      = mk_ctrl(CELL_WRITE, count_ff,
                                                  CODE_WIDTH'(BYTE_ESC));
                              count_in  = count_ff + 1'b1;
                              letter_in = dir_letter(dir_sel);
                              seq_n_in  = (mode_ff == MODE_ANSI) ? 2'd2 : 2'd1;
                              state_in  = ST_SEQ;
                           end
                        end else begin
                           acc_in   = 1'b1;
                           count_in = count_ff + 1'b1;
                           if (xlate && btn_l)
                              ctrl = mk_ctrl(CELL_WRITE, count_ff, CODE_WIDTH'(BYTE_CR));
                           else if (xlate && btn_r)
                              ctrl = mk_ctrl(CELL_WRITE, count_ff, CODE_WIDTH'(BYTE_ESC));
                           else
                              ctrl = mk_ctrl(CELL_WRITE, count_ff, code);
                        end
                     end
                  end
                  FUNC_PUSH: begin
                     if (code == '0) begin
                        acc_in = 1'b1;
                     end else if (!full) begin
                        acc_in   = 1'b1;
                        ctrl     = mk_ctrl(CELL_SHR, count_ff, code);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff != '0) begin
                        key_in   = 16'(head);
                        ctrl     = mk_ctrl(CELL_SHL, count_ff, head);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  FUNC_PEEK: begin
                     if (count_ff != '0) key_in = 16'(head);
                  end
                  FUNC_PURGE: begin
                     if (count_ff != '0) begin
                        match_in = code;
                        left_in  = count_ff;
                        state_in = ST_PURGE;
                     end
                  end
                  FUNC_CLEAR: count_in = '0;
                  default:    acc_in   = 1'b0;
               endcase
            end
         end
         ST_SEQ: begin
            if (seq_n_ff == 2'd2)
               ctrl = mk_ctrl(CELL_WRITE, count_ff, CODE_WIDTH'(BYTE_BRACKET));
            else
               ctrl = mk_ctrl(CELL_WRITE, count_ff, CODE_WIDTH'(letter_ff));
            count_in = count_ff + 1'b1;
            seq_n_in = seq_n_ff - 1'b1;
            if (seq_n_ff == 2'd1) state_in = ST_RESP;
         end
         ST_PURGE: begin
            // head leaves the queue; it comes back at the tail unless it matches
            ctrl = mk_ctrl(CELL_SHL, count_ff, head);
            if (head == match_ff) begin
               found_in = 1'b1;
               count_in = count_ff - 1'b1;
            end
            left_in = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) state_in = ST_RESP;
         end
         default: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         left_ff  <= '0;
         seq_n_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         seq_n_ff <= seq_n_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      match_ff  <= match_in;
      acc_ff    <= acc_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
   end

   // the cell row, head at cell 0
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic [CODE_WIDTH-1:0] prev_v, next_v;
      if (i == 0) begin : g_first
         assign prev_v = ctrl.data[CODE_WIDTH-1:0];
      end else begin : g_mid
         assign prev_v = cell_q[i-1];
      end
      if (i == NCELL - 1) begin : g_last
         assign next_v = ctrl.data[CODE_WIDTH-1:0];
      end else begin : g_inner
         assign next_v = cell_q[i+1];
      end
      krb_cell #(
         .CODE_WIDTH (CODE_WIDTH),
         .LEN_W      (CNT_W),
         .IDX        (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .from_prev (prev_v),
         .from_next (next_v),
         .value     (cell_q[i])
      );
   end

   // handshake and result
   logic [FILL_W+CNT_W-1:0] fill_ext;
   assign fill_ext = {{FILL_W{1'b0}}, count_ff};

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_accepted   = acc_ff;
   assign rsp_key_out    = key_ff;
   assign rsp_found      = found_ff;
   assign rsp_fill_level = fill_ext[FILL_W-1:0];
   assign rsp_is_full    = full;
endmodule

/* sim/key_ring_buffer_with_escape_translate_unit_tb.sv */
// ----------------------------------------------------------------------------
// key_ring_buffer_with_escape_translate_unit_tb
// self-checking bench for the key-code ring buffer with escape translation
// ----------------------------------------------------------------------------
// A queue-fed driver sends key transactions and a monitor checks every result
// against an in-bench model of the buffer. The run steps through several
// translation settings (raw, ANSI, VT52, unused mode) and four traffic
// patterns: no idling, an idle sender, a stalling receiver, and both.
// ----------------------------------------------------------------------------
module key_ring_buffer_with_escape_translate_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import krb_pkg::*;

   localparam int SLOTS      = 128;
   localparam int MAX_KEYS   = SLOTS - 1;
   localparam int CYCLE_CAP  = 1500000;
   localparam int N_PHASES   = 8;
   localparam int PHASE_KEYS = 240;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [15:0]       code;
   } key_txn_type;

   typedef struct {
      logic              accepted;
      logic [15:0]       key_out;
      logic              found;
      logic [FILL_W-1:0] fill_level;
      logic              is_full;
   } key_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [15:0] req_key_code = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_accepted;
   logic [15:0] rsp_key_out;
   logic rsp_found;
   logic [FILL_W-1:0] rsp_fill_level;
   logic rsp_is_full;
   logic csr_wr_en = 1'b0;
   logic [CSR_A_W-1:0] csr_index = '0;
   logic [CSR_D_W-1:0] csr_wr_data = '0;

   key_ring_buffer_with_escape_translate_unit u_top (.*);

   // clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state of the key buffer
   logic [15:0] key_mem [SLOTS];
   int          key_head;
   int          key_count;
   logic [1:0]  emu_mode;
   logic [63:0] arrow_reg;
   logic [63:0] mouse_reg;
   logic [31:0] button_reg;

   key_txn_type pending_keys[$];
   key_rsp_type expected_rsps[$];
   logic [15:0] code_pool[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic req_taken = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int rsp_checked = 0;
   int keys_sent = 0;

   // append one code at the tail
   function automatic void tail_append(logic [15:0] c);
      key_mem[(key_head + key_count) % SLOTS] = c;
      key_count++;
   endfunction

   function automatic logic put_translated(logic [15:0] c);
      logic [7:0] letter [4];
      int len;
      letter[0] = "D"; letter[1] = "A"; letter[2] = "C"; letter[3] = "B";
      if (c == 16'h0) return 1'b1;
      if (key_count >= MAX_KEYS) return 1'b0;
      if (emu_mode == MODE_ANSI || emu_mode == MODE_VT52) begin
         // arrow and mouse moves first, left-up-right-down, then buttons
         for (int d = 0; d < 4; d++) begin
            if (c == arrow_reg[16*d +: 16] || c == mouse_reg[16*d +: 16]) begin
               len = (emu_mode == MODE_ANSI) ? 3 : 2;
               // sequence stored whole or not at all
               if (key_count + len > MAX_KEYS) return 1'b0;
               tail_append(16'(BYTE_ESC));
               if (emu_mode == MODE_ANSI) tail_append(16'(BYTE_BRACKET));
               tail_append(16'(letter[d]));
               return 1'b1;
            end
         end
         if (c == button_reg[15:0]) begin
            tail_append(16'(BYTE_CR));
            return 1'b1;
         end
         if (c == button_reg[31:16]) begin
            tail_append(16'(BYTE_ESC));
            return 1'b1;
         end
      end
      tail_append(c);
      return 1'b1;
   endfunction

   function automatic key_rsp_type predict_key_rsp(key_txn_type t);
      key_rsp_type r;
      int rd, wr, kept;
      r = '{default: '0};
      case (t.func)
         FUNC_PUT: r.accepted = put_translated(t.code);
         FUNC_PUSH: begin
            if (t.code == 16'h0) r.accepted = 1'b1;
            else if (key_count < MAX_KEYS) begin
               key_head = (key_head + SLOTS - 1) % SLOTS;
               key_mem[key_head] = t.code;
               key_count++;
               r.accepted = 1'b1;
            end
         end
         FUNC_POP: begin
            if (key_count != 0) begin
               r.key_out = key_mem[key_head];
               key_head = (key_head + 1) % SLOTS;
               key_count--;
            end
         end
         FUNC_PEEK: if (key_count != 0) r.key_out = key_mem[key_head];
         FUNC_PURGE: begin
            // drop every match and close the gaps in order
            rd = key_head; wr = key_head; kept = 0;
            for (int i = 0; i < key_count; i++) begin
               if (key_mem[rd] == t.code) r.found = 1'b1;
               else begin
                  key_mem[wr] = key_mem[rd];
                  wr = (wr + 1) % SLOTS;
                  kept++;
               end
               rd = (rd + 1) % SLOTS;
            end
            key_count = kept;
         end
         FUNC_CLEAR: begin
            key_head = 0;
            key_count = 0;
         end
         default: ;
      endcase
      r.fill_level = FILL_W'(key_count);
      r.is_full = (key_count >= MAX_KEYS);
      return r;
   endfunction

   // driver: new transaction at the falling edge once the last one was taken
   always @(negedge clock) begin
      key_txn_type t;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_keys.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            t = pending_keys.pop_front();
            req_valid <= 1'b1;
            req_func <= t.func;
            req_key_code <= t.code;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // monitor: predict on request accept, compare on result accept
   always @(posedge clock) begin
      key_txn_type t;
      key_rsp_type e;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         req_taken <= req_valid && !req_stall && !reset;
         if (!reset && req_valid && !req_stall) begin
            t.func = req_func;
            t.code = req_key_code;
            expected_rsps.push_back(predict_key_rsp(t));
            keys_sent++;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result at cycle %0d", cycle_count);
            end else begin
               e = expected_rsps.pop_front();
               rsp_checked++;
               if (rsp_accepted !== e.accepted || rsp_key_out !== e.key_out ||
                   rsp_found !== e.found || rsp_fill_level !== e.fill_level ||
                   rsp_is_full !== e.is_full) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch #%0d: exp acc=%b key=%h fnd=%b fill=%0d full=%b,",
                               " got acc=%b key=%h fnd=%b fill=%0d full=%b"},
                              rsp_checked, e.accepted, e.key_out, e.found, e.fill_level,
                              e.is_full, rsp_accepted, rsp_key_out, rsp_found,
                              rsp_fill_level, rsp_is_full);
               end
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_A_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_MODE:   emu_mode = val[1:0];
         CSR_ARROW:  arrow_reg = val;
         CSR_MOUSE:  mouse_reg = val;
         CSR_BUTTON: button_reg = val[31:0];
         default: ;
      endcase
   endtask

   // block must be quiet before any register write
   task automatic wait_quiet();
      while (pending_keys.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void queue_key(logic [FUNC_W-1:0] f, logic [15:0] c);
      key_txn_type t;
      t.func = f;
      t.code = c;
      pending_keys.push_back(t);
   endfunction

   // mostly codes the block reacts to, so translations and purge hits happen
   function automatic logic [15:0] pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 16'h0;
      if (r < 60) return code_pool[$urandom_range(0, code_pool.size() - 1)];
      return 16'($urandom);
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 36) return FUNC_PUT;
      if (r < 46) return FUNC_PUSH;
      if (r < 66) return FUNC_POP;
      if (r < 74) return FUNC_PEEK;
      if (r < 87) return FUNC_PURGE;
      if (r < 91) return FUNC_CLEAR;
      if (r < 96) return FUNC_W'($urandom_range(0, 5));
      return FUNC_W'($urandom_range(6, 7));
   endfunction

   function automatic logic [15:0] pool_code();
      // keep configured codes clear of the escape bytes
      return 16'($urandom_range(16'h0100, 16'hFFFE));
   endfunction

   initial begin
      logic [63:0] arr, mou;
      logic [31:0] btn;
      logic [1:0] mode;
      int n, burst;
      key_head = 0;
      key_count = 0;
      emu_mode = '0;
      arrow_reg = '0;
      mouse_reg = '0;
      button_reg = '0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty reads, zero code, edge codes, unused funcs, ANSI words
      arr = {16'h0400, 16'h0300, 16'h0200, 16'h0100};
      mou = {16'h0800, 16'h0700, 16'h0600, 16'h0500};
      btn = {16'h0A00, 16'h0900};
      write_csr(CSR_ARROW, arr);
      write_csr(CSR_MOUSE, mou);
      write_csr(CSR_BUTTON, btn);
      write_csr(CSR_MODE, {62'h0, MODE_ANSI});
      @(negedge clock) csr_wr_en <= 1'b0;
      queue_key(FUNC_POP, 16'hFFFF);
      queue_key(FUNC_PEEK, 16'h0);
      queue_key(FUNC_PUT, 16'h0);
      queue_key(FUNC_PUSH, 16'h0);
      queue_key(FUNC_PUT, 16'hFFFF);
      queue_key(FUNC_PUSH, 16'h0001);
      for (int d = 0; d < 4; d++) queue_key(FUNC_PUT, arr[16*d +: 16]);
      for (int d = 0; d < 4; d++) queue_key(FUNC_PUT, mou[16*d +: 16]);
      queue_key(FUNC_PUT, btn[15:0]);
      queue_key(FUNC_PUT, btn[31:16]);
      queue_key(FUNC_PEEK, 16'h0);
      queue_key(FUNC_POP, 16'h0);
      queue_key(FUNC_PURGE, 16'(BYTE_ESC));
      queue_key(FUNC_PURGE, 16'h5555);
      queue_key(3'd6, 16'hFFFF);
      queue_key(3'd7, 16'h0);
      queue_key(FUNC_CLEAR, 16'h0);
      queue_key(FUNC_POP, 16'h0);

      for (int p = 0; p < N_PHASES; p++) begin
         wait_quiet();
         // register settings: all-zero and all-ones codes at the extremes
         case (p)
            0: begin arr = '0; mou = '0; btn = '0; end
            1: begin arr = '1; mou = '1; btn = '1; end
            default: begin
               arr = {pool_code(), pool_code(), pool_code(), pool_code()};
               mou = {pool_code(), pool_code(), pool_code(), pool_code()};
               btn = {pool_code(), pool_code()};
            end
         endcase
         mode = 2'(p % 4);
         if (p == 1) mode = MODE_VT52;
         write_csr(CSR_MODE, {62'h0, mode});
         write_csr(CSR_ARROW, arr);
         write_csr(CSR_MOUSE, mou);
         write_csr(CSR_BUTTON, btn);
         @(negedge clock) csr_wr_en <= 1'b0;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         code_pool.delete();
         for (int d = 0; d < 4; d++) begin
            code_pool.push_back(arr[16*d +: 16]);
            code_pool.push_back(mou[16*d +: 16]);
         end
         code_pool.push_back(btn[15:0]);
         code_pool.push_back(btn[31:16]);
         code_pool.push_back(16'(BYTE_ESC));
         code_pool.push_back(16'(BYTE_CR));
         code_pool.push_back(16'h1234);
         code_pool.push_back(16'hFFFF);
         n = 0;
         while (n < PHASE_KEYS) begin
            if ($urandom_range(0, 99) < 6) begin
               // fill run toward a full buffer and over-long sequences
               burst = $urandom_range(20, 140);
               for (int i = 0; i < burst; i++)
                  queue_key(($urandom_range(0, 9) < 8) ? FUNC_PUT : FUNC_PUSH,
                            pick_code());
               n += burst;
            end else begin
               queue_key(pick_func(), pick_code());
               n++;
            end
         end
      end

      // drain, then let the block settle
      wait_quiet();
      repeat (200) @(posedge clock);
      $display("sent %0d key transactions over %0d settings,", keys_sent, N_PHASES + 1);
      $display("%0d results checked, %0d mismatches", rsp_checked, mismatch_count);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
